// ----- sv/fwrw_pkg.sv -----
// Shared types and constants for the fixed-weight random word generator.
// Used by fwrw_lfsr, fwrw_mod_unit and fixed_weight_random_word.
package fwrw_pkg;

   localparam int LFSR_BITS   = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int CHUNK_BITS  = 8;
   localparam int COUNT_BITS  = 5;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 64;

   localparam int TAP_A = 63;
   localparam int TAP_B = 61;
   localparam int TAP_C = 60;
   localparam int TAP_D = 0;

   localparam logic [LFSR_BITS-1:0] LFSR_RESET = 64'h0000_0000_0000_0001;
   localparam logic [0:0] CSR_IDX_SEED = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_REDUCE,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      logic load;
      logic advance;
   } lfsr_ctl_type;

   typedef struct packed {
      logic step;
      logic first;
   } mod_ctl_type;

endpackage

// ----- sv/fixed_weight_random_word.sv -----
// Fixed-weight random word: each request yields a shuffled word with the requested number of ones (at most WORD_BITS).
// Each swap step takes two passes of the shared remainder unit (ST_STEP, then ST_REDUCE).
// A request is taken only in ST_IDLE; the next request is taken while a result waits.
// Reset returns the LFSR and seed register to 1 and leaves the block idle.
// Depends on fwrw_pkg, fwrw_lfsr and fwrw_mod_unit.
module fixed_weight_random_word #(
   parameter int WORD_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [fwrw_pkg::COUNT_BITS-1:0]      req_ones_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [fwrw_pkg::SAMPLE_BITS-1:0]     rsp_random_word,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fwrw_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [fwrw_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [fwrw_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int IDX_W = $clog2(WORD_BITS);

   fwrw_pkg::seq_state_type state_ff, state_in;
   fwrw_pkg::lfsr_ctl_type  lfsr_ctl;
   fwrw_pkg::mod_ctl_type   mod_ctl;

   logic [fwrw_pkg::LFSR_BITS-1:0]  seed_ff, seed_in;
   logic [fwrw_pkg::LFSR_BITS-1:0]  lfsr_state, lfsr_step;
   logic [WORD_BITS-1:0]            vec_ff, vec_in;
   logic [IDX_W-1:0]                idx_ff, idx_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [fwrw_pkg::SAMPLE_BITS-1:0] rsp_word_ff, rsp_word_in;
   logic [fwrw_pkg::CHUNK_BITS-1:0] mod_chunk;
   logic [IDX_W:0]                  divisor;
   logic [IDX_W-1:0]                swap_idx;
   logic [fwrw_pkg::COUNT_BITS-1:0] count_sat;
   logic                            csr_write, req_fire, rsp_load;

   assign csr_write = csr_psel & csr_penable & csr_pwrite
                    & (csr_paddr[fwrw_pkg::CSR_ADDR_BITS-1] == fwrw_pkg::CSR_IDX_SEED);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[fwrw_pkg::CSR_ADDR_BITS-1] == fwrw_pkg::CSR_IDX_SEED)
                     ? seed_ff : '0;

   assign req_fire = req_valid & req_ready;
   assign rsp_load = (state_ff == fwrw_pkg::ST_FINISH) & (~rsp_valid_ff | rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fwrw_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = fwrw_pkg::ST_STEP;
            end
         end
         fwrw_pkg::ST_STEP: begin
            state_in = fwrw_pkg::ST_REDUCE;
         end
         fwrw_pkg::ST_REDUCE: begin
            if (idx_ff == IDX_W'(1)) begin
               state_in = fwrw_pkg::ST_FINISH;
            end else begin
               state_in = fwrw_pkg::ST_STEP;
            end
         end
         fwrw_pkg::ST_FINISH: begin
            if (~rsp_valid_ff | rsp_ready) begin
               state_in = fwrw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fwrw_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      lfsr_ctl.load = csr_write;
      lfsr_ctl.advance = 1'b0;
      mod_ctl.step = 1'b0;
      mod_ctl.first = 1'b0;
      mod_chunk = lfsr_state[fwrw_pkg::CHUNK_BITS-1:0];
      case (state_ff)
         fwrw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         fwrw_pkg::ST_STEP: begin
            lfsr_ctl.advance = 1'b1;
            mod_ctl.step = 1'b1;
            mod_ctl.first = 1'b1;
            mod_chunk = lfsr_step[fwrw_pkg::SAMPLE_BITS-1:fwrw_pkg::CHUNK_BITS];
         end
         fwrw_pkg::ST_REDUCE: begin
            mod_ctl.step = 1'b1;
         end
         fwrw_pkg::ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   assign divisor = {1'b0, idx_ff} + (IDX_W+1)'(1);
   assign count_sat = (req_ones_count > fwrw_pkg::COUNT_BITS'(WORD_BITS))
                    ? fwrw_pkg::COUNT_BITS'(WORD_BITS) : req_ones_count;

   fwrw_lfsr u_lfsr (
      .clock      (clock),
      .reset      (reset),
      .ctl        (lfsr_ctl),
      .seed       (csr_pwdata),
      .state      (lfsr_state),
      .state_next (lfsr_step)
   );

   fwrw_mod_unit #(
      .REM_W (IDX_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mod_ctl),
      .chunk     (mod_chunk),
      .divisor   (divisor),
      .remainder (swap_idx)
   );

   always_comb begin
      vec_in = vec_ff;
      idx_in = idx_ff;
      if (req_fire) begin
         for (int k = 0; k < WORD_BITS; k++) begin
            vec_in[k] = (fwrw_pkg::COUNT_BITS'(k) < count_sat);
         end
         idx_in = IDX_W'(WORD_BITS - 1);
      end else if (state_ff == fwrw_pkg::ST_REDUCE) begin
         if (vec_ff[idx_ff] != vec_ff[swap_idx]) begin
            vec_in[idx_ff] = ~vec_ff[idx_ff];
            vec_in[swap_idx] = ~vec_ff[swap_idx];
         end
         idx_in = idx_ff - IDX_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in = rsp_word_ff;
      seed_in = csr_write ? csr_pwdata : seed_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in = fwrw_pkg::SAMPLE_BITS'(vec_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fwrw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         seed_ff <= fwrw_pkg::LFSR_RESET;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         seed_ff <= seed_in;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
      idx_ff <= idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;

endmodule

// ----- sv/fwrw_lfsr.sv -----
// 64-bit Galois-free shift-right LFSR with seed reload.
// Depends on fwrw_pkg for widths, taps and control struct.
module fwrw_lfsr (
   input  logic                            clock,
   input  logic                            reset,
   input  fwrw_pkg::lfsr_ctl_type          ctl,
   input  logic [fwrw_pkg::LFSR_BITS-1:0]  seed,
   output logic [fwrw_pkg::LFSR_BITS-1:0]  state,
   output logic [fwrw_pkg::LFSR_BITS-1:0]  state_next
);

   logic [fwrw_pkg::LFSR_BITS-1:0] lfsr_ff;
   logic [fwrw_pkg::LFSR_BITS-1:0] lfsr_in;
   logic                           feedback;

   always_comb begin
      feedback = lfsr_ff[fwrw_pkg::TAP_A] ^ lfsr_ff[fwrw_pkg::TAP_B]
               ^ lfsr_ff[fwrw_pkg::TAP_C] ^ lfsr_ff[fwrw_pkg::TAP_D];
      state_next = {feedback, lfsr_ff[fwrw_pkg::LFSR_BITS-1:1]};
      lfsr_in = lfsr_ff;
      if (ctl.load) begin
         lfsr_in = (seed == '0) ? fwrw_pkg::LFSR_RESET : seed;
      end else if (ctl.advance) begin
         lfsr_in = state_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= fwrw_pkg::LFSR_RESET;
      end else begin
         lfsr_ff <= lfsr_in;
      end
   end

   assign state = lfsr_ff;

endmodule

// ----- sv/fwrw_mod_unit.sv -----
// Shared remainder unit: restoring reduction of one byte per cycle in which ctl.step is set, against a small divisor.
// Depends on fwrw_pkg for the chunk width and control struct.
module fwrw_mod_unit #(
   parameter int REM_W = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fwrw_pkg::mod_ctl_type             ctl,
   input  logic [fwrw_pkg::CHUNK_BITS-1:0]   chunk,
   input  logic [REM_W:0]                    divisor,
   output logic [REM_W-1:0]                  remainder
);

   logic [REM_W-1:0] rem_ff;
   logic [REM_W-1:0] rem_in;
   logic [REM_W:0]   trial;

   always_comb begin
      rem_in = ctl.first ? '0 : rem_ff;
      trial = '0;
      for (int b = fwrw_pkg::CHUNK_BITS - 1; b >= 0; b--) begin
         trial = {rem_in, chunk[b]};
         if (trial >= divisor) begin
            trial = trial - divisor;
         end
         rem_in = trial[REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else if (ctl.step) begin
         rem_ff <= rem_in;
      end
   end

   assign remainder = rem_in;

endmodule
